// ----- hdl/lba_pkg.sv -----
package lba_pkg;

    localparam int unsigned POOL_ENTRIES_DEF = 4096;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned COUNT_W = 13;

    typedef enum logic [1:0] {
        FUNC_MARK    = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_TEST    = 2'd2,
        FUNC_BAD     = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_RANGE = 3'd1,
        ST_TAKEN = 3'd2,
        ST_FREE  = 3'd3,
        ST_BADOP = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        REG_RANGE_FIRST = 1'b0,
        REG_RANGE_LAST  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_func              func;
        logic [ADDR_W-1:0]  req_address;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic               is_taken;
        logic [COUNT_W-1:0] free_count;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
    } t_pool_cfg;

endpackage

// ----- hdl/lba_ram.sv -----
module lba_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/lba_init.sv -----
module lba_init #(
    parameter int unsigned POOL_ENTRIES = lba_pkg::POOL_ENTRIES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  lba_pkg::t_reg_idx                      i_cfg_index,
    input  logic [lba_pkg::ADDR_W-1:0]             i_cfg_data,
    output lba_pkg::t_pool_cfg                     o_cfg,
    output logic                                   o_busy,
    output logic [$clog2(POOL_ENTRIES)-1:0]        o_clr_idx,
    output logic [$clog2(POOL_ENTRIES+1)-1:0]      o_size
);

    import lba_pkg::*;

    localparam int unsigned AW    = $clog2(POOL_ENTRIES);
    localparam int unsigned CNT_W = $clog2(POOL_ENTRIES + 1);

    t_pool_cfg         r_cfg;
    logic              r_busy;
    logic [AW-1:0]     r_clr_idx;
    logic [ADDR_W:0]   span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= '0;
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RANGE_FIRST: r_cfg.first <= i_cfg_data;
                REG_RANGE_LAST:  r_cfg.last  <= i_cfg_data;
                default:         r_cfg       <= r_cfg;
            endcase
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            if (r_clr_idx == AW'(POOL_ENTRIES - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    assign span = {1'b0, r_cfg.last} - {1'b0, r_cfg.first} + (ADDR_W+1)'(1);

    always_comb begin
        if (r_cfg.last < r_cfg.first) begin
            o_size = '0;
        end else if (span > (ADDR_W+1)'(POOL_ENTRIES)) begin
            o_size = CNT_W'(POOL_ENTRIES);
        end else begin
            o_size = span[CNT_W-1:0];
        end
    end

    assign o_cfg     = r_cfg;
    assign o_busy    = r_busy;
    assign o_clr_idx = r_clr_idx;

endmodule

// ----- hdl/lease_bitmap_allocator.sv -----
// An item is registered in stage one, then its result in the output
// register. One item per cycle unless stalled; the mark store
// read-modify-write is forwarded so back-to-back items on the same
// address need no bubble. Reset and every register write start a clearing
// sweep of all POOL_ENTRIES entries (one per cycle) accepting no item.
module lease_bitmap_allocator #(
    parameter int unsigned POOL_ENTRIES = lba_pkg::POOL_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  lba_pkg::t_req               i_item,
    output logic                        o_valid,
    input  logic                        i_stall,
    output lba_pkg::t_result            o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  lba_pkg::t_reg_idx           i_cfg_index,
    input  logic [lba_pkg::ADDR_W-1:0]  i_cfg_data
);

    import lba_pkg::*;

    localparam int unsigned AW    = $clog2(POOL_ENTRIES);
    localparam int unsigned CNT_W = $clog2(POOL_ENTRIES + 1);

    t_pool_cfg         cfg;
    logic              clr_busy;
    logic [AW-1:0]     clr_idx;
    logic [CNT_W-1:0]  pool_size;

    logic              in_accept;
    logic [ADDR_W-1:0] in_offset;
    logic              in_range;
    logic [AW-1:0]     in_slot;

    logic              r_s1_valid;
    t_func             r_s1_func;
    logic              r_s1_in_range;
    logic [AW-1:0]     r_s1_slot;
    logic              r_s1_fwd;
    logic              r_s1_fwd_val;

    logic [0:0]        ram_rdata;
    logic              s1_done;
    logic              s1_taken;
    logic              s1_wr;
    logic              s1_wdata;
    t_status           s1_status;
    logic [CNT_W-1:0]  n_free;
    logic [CNT_W+COUNT_W-1:0] free_wide;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [0:0]        ram_wdata;

    logic              r_out_valid;
    t_result           r_out;
    logic [CNT_W-1:0]  r_free;

    lba_init #(
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_init (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_busy      (clr_busy),
        .o_clr_idx   (clr_idx),
        .o_size      (pool_size)
    );

    lba_ram #(
        .WIDTH (1),
        .DEPTH (POOL_ENTRIES)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (in_slot),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready = 1'b1;

    assign s1_done   = r_s1_valid & (~r_out_valid | ~i_stall);
    assign o_stall   = clr_busy | (r_s1_valid & ~s1_done);
    assign in_accept = i_valid & ~o_stall;

    assign in_offset = i_item.req_address - cfg.first;
    assign in_range  = (i_item.req_address >= cfg.first) &&
                       (i_item.req_address <= cfg.last) &&
                       ({1'b0, in_offset} < (ADDR_W+1)'(POOL_ENTRIES));
    assign in_slot   = in_offset[AW-1:0];

    assign s1_taken = r_s1_fwd ? r_s1_fwd_val : ram_rdata[0];

    always_comb begin
        s1_status = ST_OK;
        s1_wr     = 1'b0;
        s1_wdata  = 1'b0;
        n_free    = r_free;
        if (!r_s1_in_range) begin
            s1_status = ST_RANGE;
        end else begin
            case (r_s1_func)
                FUNC_MARK: begin
                    if (s1_taken) begin
                        s1_status = ST_TAKEN;
                    end else begin
                        s1_wr    = 1'b1;
                        s1_wdata = 1'b1;
                        if (r_free != '0) begin
                            n_free = r_free - 1'b1;
                        end
                    end
                end
                FUNC_RELEASE: begin
                    if (!s1_taken) begin
                        s1_status = ST_FREE;
                    end else begin
                        s1_wr = 1'b1;
                        if (r_free < CNT_W'(POOL_ENTRIES)) begin
                            n_free = r_free + 1'b1;
                        end
                    end
                end
                FUNC_TEST: s1_status = ST_OK;
                default:   s1_status = ST_BADOP;
            endcase
        end
    end

    assign free_wide = {{COUNT_W{1'b0}}, n_free};

    assign ram_we    = clr_busy | (s1_done & s1_wr);
    assign ram_waddr = clr_busy ? clr_idx : r_s1_slot;
    assign ram_wdata = clr_busy ? 1'b0 : s1_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_free      <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (clr_busy) begin
                r_free <= pool_size;
            end else if (s1_done) begin
                r_free <= n_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_func     <= i_item.func;
            r_s1_in_range <= in_range;
            r_s1_slot     <= in_slot;
            r_s1_fwd      <= s1_done & s1_wr & (r_s1_slot == in_slot);
            r_s1_fwd_val  <= s1_wdata;
        end
        if (s1_done) begin
            r_out.status     <= s1_status;
            r_out.is_taken   <= r_s1_in_range & s1_taken;
            r_out.free_count <= free_wide[COUNT_W-1:0];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_clear_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(clr_busy && (r_s1_valid || in_accept)))
        else $error("item in flight during clearing sweep");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= CNT_W'(POOL_ENTRIES))
        else $error("free count above pool capacity");

    a_mark_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_done && s1_wr && s1_wdata && !clr_busy && r_free != '0)
        |=> (r_free == $past(r_free) - 1'b1))
        else $error("successful mark did not consume a free entry");

    a_fail_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_done && s1_status != ST_OK) |-> !s1_wr)
        else $error("failed request modified the mark store");

endmodule
